[rtl/dcih_pkg.sv]
package dcih_pkg;

    // Widths of the transaction fields.
    localparam int unsigned CMD_W  = 3;
    localparam int unsigned ADDR_W = 10;
    localparam int unsigned BYTE_W = 8;

    // Kinds of input transaction.
    typedef enum logic [CMD_W-1:0] {
        CMD_MAIN_RD  = 3'd0,
        CMD_MAIN_WR  = 3'd1,
        CMD_SUB_RD   = 3'd2,
        CMD_SUB_WR   = 3'd3,
        CMD_TICK     = 3'd4,
        CMD_MAIN_ACK = 3'd5,
        CMD_SUB_ACK  = 3'd6
    } cmd_t;

    // Acknowledged line codes.
    localparam logic ACK_IRQ  = 1'b0;
    localparam logic ACK_FIRQ = 1'b1;

    // Main CPU port offsets.
    localparam logic [ADDR_W-1:0] MAIN_MASK   = 10'h002;
    localparam logic [ADDR_W-1:0] MAIN_CAUSE  = 10'h003;
    localparam logic [ADDR_W-1:0] MAIN_ATTN   = 10'h004;
    localparam logic [ADDR_W-1:0] MAIN_SUBCTL = 10'h005;
    localparam logic [ADDR_W-1:0] MAIN_ROM    = 10'h00f;

    // Sub CPU port offsets.
    localparam logic [ADDR_W-1:0] SUB_IRQ_CLR = 10'h002;
    localparam logic [ADDR_W-1:0] SUB_ATTN    = 10'h004;
    localparam logic [ADDR_W-1:0] SUB_BUSY    = 10'h00a;

    // Bit constants.
    localparam logic [BYTE_W-1:0] TIMER_BIT  = 8'h04;
    localparam logic [BYTE_W-1:0] HALT_BIT   = 8'h80;
    localparam logic [BYTE_W-1:0] SUBIRQ_BIT = 8'h40;
    localparam logic [BYTE_W-1:0] ATTN_BIT   = 8'h01;
    localparam logic [BYTE_W-1:0] ALL_ONES   = 8'hff;

    // One input transaction.
    typedef struct packed {
        cmd_t              command;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] data;
        logic              ack_line;
    } item_t;

    // One result transaction.
    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              main_irq;
        logic              main_firq;
        logic              sub_halt;
        logic              sub_irq;
        logic              rom_select;
    } result_t;

endpackage

[rtl/dual_cpu_irq_and_handshake_ports.sv]
// Channel   Direction  Contents
// s_axis    in         tuser: command; tdata: address, data, ack_line
// m_axis    out        tdata: read_data, main_irq, main_firq, sub_halt, sub_irq, rom_select
//
// Each transaction is held in an input register, decoded combinationally against
// the flag state and stored in a result register; one transaction is accepted
// per cycle while the output side keeps taking results.
// Reset sets the mask to all ones and busy and ROM-enable to one; lines clear.
// A stall at m_axis holds the result; the input register absorbs one more.
module dual_cpu_irq_and_handshake_ports (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [9:0] address, [17:10] data, [18] ack_line
    input  logic [2:0]  s_axis_tuser,  // [2:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // [7:0] read_data, [8] main_irq, [9] main_firq,
                                       // [10] sub_halt, [11] sub_irq, [12] rom_select
);

    dcih_pkg::item_t   in_item;
    dcih_pkg::item_t   item;
    dcih_pkg::result_t result;
    dcih_pkg::result_t out_result;
    logic              step;
    logic              out_free;

    // Unpack the incoming transaction.
    always_comb
    begin
        in_item.command  = dcih_pkg::cmd_t'(s_axis_tuser);
        in_item.address  = s_axis_tdata[9:0];
        in_item.data     = s_axis_tdata[17:10];
        in_item.ack_line = s_axis_tdata[18];
    end

    dcih_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .out_free (out_free),
        .step     (step),
        .item     (item)
    );

    dcih_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .result (result)
    );

    dcih_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .result     (result),
        .out_free   (out_free),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    // Pack the result transaction.
    assign m_axis_tdata = {3'b000, out_result.rom_select, out_result.sub_irq,
                           out_result.sub_halt, out_result.main_firq,
                           out_result.main_irq, out_result.read_data};

endmodule

[rtl/dcih_in_stage.sv]
module dcih_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  dcih_pkg::item_t in_item,
    input  logic            out_free,
    output logic            step,
    output dcih_pkg::item_t item
);

    logic            valid_reg;
    dcih_pkg::item_t item_reg;

    // The held item moves on whenever the result register can take it.
    assign step     = valid_reg && out_free;
    assign in_ready = !valid_reg || out_free;
    assign item     = item_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload capture.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

[rtl/dcih_core.sv]
module dcih_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  dcih_pkg::item_t   item,
    output dcih_pkg::result_t result
);

    logic [dcih_pkg::BYTE_W-1:0] mask_reg, mask_next;
    logic [dcih_pkg::BYTE_W-1:0] pend_reg, pend_next;
    logic attn_reg, attn_next;
    logic busy_reg, busy_next;
    logic rom_reg, rom_next;
    logic main_irq_reg, main_irq_next;
    logic main_firq_reg, main_firq_next;
    logic sub_halt_reg, sub_halt_next;
    logic sub_irq_reg, sub_irq_next;
    logic [dcih_pkg::BYTE_W-1:0] rd;

    // Next state and read byte for the current transaction.
    always_comb
    begin
        mask_next      = mask_reg;
        pend_next      = pend_reg;
        attn_next      = attn_reg;
        busy_next      = busy_reg;
        rom_next       = rom_reg;
        main_irq_next  = main_irq_reg;
        main_firq_next = main_firq_reg;
        sub_halt_next  = sub_halt_reg;
        sub_irq_next   = sub_irq_reg;
        rd             = '0;
        unique case (item.command)
            dcih_pkg::CMD_MAIN_RD:
            begin
                if (item.address == dcih_pkg::MAIN_CAUSE)
                begin
                    rd        = pend_reg;
                    pend_next = '0;
                end
                else if (item.address == dcih_pkg::MAIN_ATTN)
                begin
                    rd        = attn_reg ? (dcih_pkg::ALL_ONES & ~dcih_pkg::ATTN_BIT)
                                         : dcih_pkg::ALL_ONES;
                    attn_next = 1'b0;
                end
                else if (item.address == dcih_pkg::MAIN_SUBCTL)
                begin
                    rd = busy_reg ? dcih_pkg::HALT_BIT : '0;
                end
                else if (item.address == dcih_pkg::MAIN_ROM)
                begin
                    rom_next = 1'b1;
                end
            end
            dcih_pkg::CMD_MAIN_WR:
            begin
                if (item.address == dcih_pkg::MAIN_MASK)
                begin
                    mask_next = item.data;
                end
                else if (item.address == dcih_pkg::MAIN_SUBCTL)
                begin
                    sub_halt_next = |(item.data & dcih_pkg::HALT_BIT);
                    if (|(item.data & dcih_pkg::SUBIRQ_BIT))
                    begin
                        sub_irq_next = 1'b1;
                    end
                end
                else if (item.address == dcih_pkg::MAIN_ROM)
                begin
                    rom_next = 1'b0;
                end
            end
            dcih_pkg::CMD_SUB_RD:
            begin
                if (item.address == dcih_pkg::SUB_IRQ_CLR)
                begin
                    sub_irq_next = 1'b0;
                end
                else if (item.address == dcih_pkg::SUB_ATTN)
                begin
                    attn_next      = 1'b1;
                    main_firq_next = 1'b1;
                    rd             = dcih_pkg::ALL_ONES;
                end
                else if (item.address == dcih_pkg::SUB_BUSY)
                begin
                    busy_next = 1'b0;
                end
            end
            dcih_pkg::CMD_SUB_WR:
            begin
                if (item.address == dcih_pkg::SUB_BUSY)
                begin
                    busy_next = 1'b1;
                end
            end
            dcih_pkg::CMD_TICK:
            begin
                if (!(|(mask_reg & dcih_pkg::TIMER_BIT)))
                begin
                    pend_next     = pend_reg | dcih_pkg::TIMER_BIT;
                    main_irq_next = 1'b1;
                end
            end
            dcih_pkg::CMD_MAIN_ACK:
            begin
                if (item.ack_line == dcih_pkg::ACK_IRQ)
                begin
                    main_irq_next = 1'b0;
                end
                else
                begin
                    main_firq_next = 1'b0;
                end
            end
            dcih_pkg::CMD_SUB_ACK:
            begin
                if (item.ack_line == dcih_pkg::ACK_IRQ)
                begin
                    sub_irq_next = 1'b0;
                end
            end
            default:
            begin
                rd = '0;
            end
        endcase
    end

    // Result shows the line levels after the transaction.
    always_comb
    begin
        result.read_data  = rd;
        result.main_irq   = main_irq_next;
        result.main_firq  = main_firq_next;
        result.sub_halt   = sub_halt_next;
        result.sub_irq    = sub_irq_next;
        result.rom_select = rom_next;
    end

    // Flag and line state, committed when the transaction moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= dcih_pkg::ALL_ONES;
            pend_reg      <= '0;
            attn_reg      <= 1'b0;
            busy_reg      <= 1'b1;
            rom_reg       <= 1'b1;
            main_irq_reg  <= 1'b0;
            main_firq_reg <= 1'b0;
            sub_halt_reg  <= 1'b0;
            sub_irq_reg   <= 1'b0;
        end
        else if (step)
        begin
            mask_reg      <= mask_next;
            pend_reg      <= pend_next;
            attn_reg      <= attn_next;
            busy_reg      <= busy_next;
            rom_reg       <= rom_next;
            main_irq_reg  <= main_irq_next;
            main_firq_reg <= main_firq_next;
            sub_halt_reg  <= sub_halt_next;
            sub_irq_reg   <= sub_irq_next;
        end
    end

endmodule

[rtl/dcih_out_stage.sv]
module dcih_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  dcih_pkg::result_t result,
    output logic              out_free,
    output logic              out_valid,
    input  logic              out_ready,
    output dcih_pkg::result_t out_result
);

    logic              valid_reg;
    dcih_pkg::result_t result_reg;

    // Room for a new result when empty or when the held one leaves now.
    assign out_free   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= step;
        end
    end

    // Payload capture.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result;
        end
    end

endmodule
